// ===== hdl/cmbd_pkg.sv =====
package cmbd_pkg;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_COUNT    = 5'd1,
        PH_L_X      = 5'd2,
        PH_L_Y      = 5'd3,
        PH_L_VAL    = 5'd4,
        PH_COLOFF   = 5'd5,
        PH_ROWOFF   = 5'd6,
        PH_FLOAT    = 5'd7,
        PH_XFLAG    = 5'd8,
        PH_YFLAG    = 5'd9,
        PH_TYPE     = 5'd10,
        PH_S_ROWS   = 5'd11,
        PH_S_ROWNUM = 5'd12,
        PH_S_COLCNT = 5'd13,
        PH_S_COLNUM = 5'd14,
        PH_S_VAL    = 5'd15,
        PH_D_COUNT  = 5'd16,
        PH_D_WIDTH  = 5'd17,
        PH_D_VAL    = 5'd18,
        PH_DONE     = 5'd19
    } phase_t;

    typedef enum logic [1:0] {
        KIND_RECORD = 2'd0,
        KIND_END    = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    localparam logic [3:0] VERSION_RESET  = 4'd9;
    localparam logic [3:0] VERSION_HEADER = 4'd7;
    localparam logic [3:0] VERSION_FLAGS  = 4'd8;
    localparam logic [7:0] TYPE_SPARSE    = 8'd1;
    localparam logic [7:0] TYPE_DENSE     = 8'd2;
    localparam logic [15:0] SHORT_SKIP    = 16'h8000;

    typedef struct packed {
        logic       block_start;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [32:0] x_bin;
        logic [32:0] y_bin;
        logic [31:0] value_bits;
        logic        end_of_block;
    } result_t;

    // Exact conversion of a signed 16-bit integer to single precision.
    function automatic logic [31:0] short_to_float(input logic [15:0] s);
        logic [15:0] mag;
        logic [3:0]  p;
        logic [23:0] m24;
        logic [7:0]  expo;
        mag = s[15] ? (~s + 16'd1) : s;
        p = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (mag[i]) p = 4'(i);
        end
        m24 = {8'd0, mag} << (5'd23 - {1'b0, p});
        expo = 8'd127 + {4'd0, p};
        if (mag == 16'd0) return 32'd0;
        return {s[15], expo, m24[22:0]};
    endfunction

endpackage

// ===== hdl/cmbd_ifs.sv =====
interface cmbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       block_start;
    modport source (output valid, output data_byte, output block_start, input ready);
    modport sink (input valid, input data_byte, input block_start, output ready);
endinterface

interface cmbd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [32:0] x_bin;
    logic [32:0] y_bin;
    logic [31:0] value_bits;
    logic        end_of_block;
    modport source (output valid, output result_kind, output x_bin, output y_bin,
                    output value_bits, output end_of_block, input ready);
    modport sink (input valid, input result_kind, input x_bin, input y_bin,
                  input value_bits, input end_of_block, output ready);
endinterface

interface cmbd_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/cmbd_front.sv =====
module cmbd_front (
    input  logic           clk,
    input  logic           rst_n,
    cmbd_in_if.sink        in_ch,
    output logic           item_valid,
    output cmbd_pkg::item_t item,
    input  logic           item_pop
);
    import cmbd_pkg::*;

    item_t      buf_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;

    assign in_ch.ready = (count_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign item_valid  = (count_reg != 2'd0);
    assign item        = buf_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = item_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, item_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= '{block_start: in_ch.block_start,
                                     data_byte: in_ch.data_byte};
        end
    end

endmodule

// ===== hdl/cmbd_parser.sv =====
module cmbd_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  cmbd_pkg::item_t  item,
    output logic             item_pop,
    input  logic [3:0]       format_version,
    output logic             res_valid,
    output cmbd_pkg::result_t res,
    input  logic             res_ready
);
    import cmbd_pkg::*;

    phase_t      phase_reg, phase_next, ph_c;
    logic [2:0]  fbc_reg, fbc_next, fbc_c;
    logic [31:0] fsh_reg, fsh_next, fsh_c;
    logic [31:0] coff_reg, coff_next, coff_c;
    logic [31:0] roff_reg, roff_next, roff_c;
    logic        vf_reg, vf_next, vf_c;
    logic        wx_reg, wx_next, wx_c;
    logic        wy_reg, wy_next, wy_c;
    logic [31:0] outer_reg, outer_next, outer_c;
    logic [31:0] inner_reg, inner_next, inner_c;
    logic [32:0] rowb_reg, rowb_next, rowb_c;
    logic [32:0] colb_reg, colb_next, colb_c;
    logic [15:0] dw_reg, dw_next, dw_c;
    logic [15:0] dc_reg, dc_next, dc_c;

    logic        res_valid_reg;
    result_t     res_reg;

    logic        em_valid;
    result_t     em;

    logic [31:0] sh, v;
    logic [2:0]  cnt, flen;
    logic [32:0] sv_y, sv_x, s32, short_bits_x;
    logic [31:0] outer_dec, inner_dec, short_bits;
    logic [15:0] absw;
    logic [16:0] dc_inc;
    logic        skip;

    assign item_pop  = item_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // A block start clears the per-block state before the byte is parsed.
    always_comb
    begin
        if (item.block_start)
        begin
            ph_c = PH_COUNT; fbc_c = '0; fsh_c = '0; coff_c = '0; roff_c = '0;
            vf_c = 1'b0; wx_c = 1'b0; wy_c = 1'b0; outer_c = '0; inner_c = '0;
            rowb_c = '0; colb_c = '0; dw_c = '0; dc_c = '0;
        end
        else
        begin
            ph_c = phase_reg; fbc_c = fbc_reg; fsh_c = fsh_reg; coff_c = coff_reg;
            roff_c = roff_reg; vf_c = vf_reg; wx_c = wx_reg; wy_c = wy_reg;
            outer_c = outer_reg; inner_c = inner_reg; rowb_c = rowb_reg;
            colb_c = colb_reg; dw_c = dw_reg; dc_c = dc_reg;
        end
    end

    always_comb
    begin
        unique case (ph_c)
            PH_FLOAT, PH_XFLAG, PH_YFLAG, PH_TYPE: flen = 3'd1;
            PH_S_ROWS, PH_S_ROWNUM:                flen = wy_c ? 3'd4 : 3'd2;
            PH_S_COLCNT, PH_S_COLNUM:              flen = wx_c ? 3'd4 : 3'd2;
            PH_S_VAL, PH_D_VAL:                    flen = vf_c ? 3'd4 : 3'd2;
            PH_D_WIDTH:                            flen = 3'd2;
            default:                               flen = 3'd4;
        endcase
    end

    assign sh   = fsh_c | ({24'd0, item.data_byte} << {fbc_c[1:0], 3'b000});
    assign cnt  = fbc_c + 3'd1;
    assign v    = sh;
    assign sv_y = wy_c ? {v[31], v} : {{17{v[15]}}, v[15:0]};
    assign sv_x = wx_c ? {v[31], v} : {{17{v[15]}}, v[15:0]};
    assign s32  = {v[31], v};
    assign outer_dec  = outer_c - 32'd1;
    assign inner_dec  = inner_c - 32'd1;
    assign short_bits = short_to_float(v[15:0]);
    assign short_bits_x = {1'b0, short_bits};
    assign absw   = dw_c[15] ? (~dw_c + 16'd1) : dw_c;
    assign dc_inc = {1'b0, dc_c} + 17'd1;
    assign skip   = vf_c ? ((v[30:23] == 8'hFF) && (v[22:0] != 23'd0))
                         : (v[15:0] == SHORT_SKIP);

    // Next state of the parser.
    always_comb
    begin
        phase_next = ph_c; fbc_next = fbc_c; fsh_next = fsh_c; coff_next = coff_c;
        roff_next = roff_c; vf_next = vf_c; wx_next = wx_c; wy_next = wy_c;
        outer_next = outer_c; inner_next = inner_c; rowb_next = rowb_c;
        colb_next = colb_c; dw_next = dw_c; dc_next = dc_c;
        em_valid = 1'b0;
        em = '{result_kind: KIND_RECORD, x_bin: '0, y_bin: '0, value_bits: '0,
               end_of_block: 1'b0};
        if (ph_c != PH_IDLE && ph_c != PH_DONE)
        begin
            if (cnt < flen)
            begin
                fsh_next = sh;
                fbc_next = cnt;
            end
            else
            begin
                fsh_next = '0;
                fbc_next = '0;
                unique case (ph_c)
                    PH_COUNT:
                    begin
                        if (format_version < VERSION_HEADER)
                        begin
                            if (s32[32] || v == 32'd0)
                            begin
                                em_valid = 1'b1; em.result_kind = KIND_END;
                                em.end_of_block = 1'b1;
                            end
                            else
                            begin
                                outer_next = v; phase_next = PH_L_X;
                            end
                        end
                        else phase_next = PH_COLOFF;
                    end
                    PH_L_X:
                    begin
                        colb_next = s32; phase_next = PH_L_Y;
                    end
                    PH_L_Y:
                    begin
                        rowb_next = s32; phase_next = PH_L_VAL;
                    end
                    PH_L_VAL:
                    begin
                        outer_next = outer_dec; phase_next = PH_L_X;
                        em_valid = 1'b1; em.x_bin = colb_c; em.y_bin = rowb_c;
                        em.value_bits = v; em.end_of_block = (outer_dec == 32'd0);
                    end
                    PH_COLOFF:
                    begin
                        coff_next = v; phase_next = PH_ROWOFF;
                    end
                    PH_ROWOFF:
                    begin
                        roff_next = v; phase_next = PH_FLOAT;
                    end
                    PH_FLOAT:
                    begin
                        vf_next = (v == 32'd1);
                        phase_next = (format_version > VERSION_FLAGS) ? PH_XFLAG : PH_TYPE;
                    end
                    PH_XFLAG:
                    begin
                        wx_next = (v == 32'd1); phase_next = PH_YFLAG;
                    end
                    PH_YFLAG:
                    begin
                        wy_next = (v == 32'd1); phase_next = PH_TYPE;
                    end
                    PH_TYPE:
                    begin
                        if (v[7:0] == TYPE_SPARSE) phase_next = PH_S_ROWS;
                        else if (v[7:0] == TYPE_DENSE) phase_next = PH_D_COUNT;
                        else
                        begin
                            em_valid = 1'b1; em.result_kind = KIND_ERROR;
                            em.end_of_block = 1'b1;
                        end
                    end
                    PH_S_ROWS:
                    begin
                        if (sv_y[32] || sv_y == 33'd0)
                        begin
                            em_valid = 1'b1; em.result_kind = KIND_END;
                            em.end_of_block = 1'b1;
                        end
                        else
                        begin
                            outer_next = sv_y[31:0]; phase_next = PH_S_ROWNUM;
                        end
                    end
                    PH_S_ROWNUM:
                    begin
                        rowb_next = {roff_c[31], roff_c} + sv_y;
                        phase_next = PH_S_COLCNT;
                    end
                    PH_S_COLCNT:
                    begin
                        if (!sv_x[32] && sv_x != 33'd0)
                        begin
                            inner_next = sv_x[31:0]; phase_next = PH_S_COLNUM;
                        end
                        else
                        begin
                            outer_next = outer_dec;
                            if (outer_dec == 32'd0)
                            begin
                                em_valid = 1'b1; em.result_kind = KIND_END;
                                em.end_of_block = 1'b1;
                            end
                            else phase_next = PH_S_ROWNUM;
                        end
                    end
                    PH_S_COLNUM:
                    begin
                        colb_next = {coff_c[31], coff_c} + sv_x;
                        phase_next = PH_S_VAL;
                    end
                    PH_S_VAL:
                    begin
                        inner_next = inner_dec;
                        em_valid = 1'b1; em.x_bin = colb_c; em.y_bin = rowb_c;
                        em.value_bits = vf_c ? v : short_bits_x[31:0];
                        if (inner_dec == 32'd0)
                        begin
                            outer_next = outer_dec;
                            em.end_of_block = (outer_dec == 32'd0);
                            phase_next = PH_S_ROWNUM;
                        end
                        else phase_next = PH_S_COLNUM;
                    end
                    PH_D_COUNT:
                    begin
                        outer_next = v; phase_next = PH_D_WIDTH;
                    end
                    PH_D_WIDTH:
                    begin
                        if (outer_c[31] || outer_c == 32'd0)
                        begin
                            em_valid = 1'b1; em.result_kind = KIND_END;
                            em.end_of_block = 1'b1;
                        end
                        else if (v[15:0] == 16'd0)
                        begin
                            em_valid = 1'b1; em.result_kind = KIND_ERROR;
                            em.end_of_block = 1'b1;
                        end
                        else
                        begin
                            dw_next = v[15:0]; dc_next = '0;
                            rowb_next = {roff_c[31], roff_c};
                            phase_next = PH_D_VAL;
                        end
                    end
                    PH_D_VAL:
                    begin
                        if (dc_inc >= {1'b0, absw})
                        begin
                            dc_next = '0;
                            rowb_next = dw_c[15] ? (rowb_c - 33'd1) : (rowb_c + 33'd1);
                        end
                        else dc_next = dc_inc[15:0];
                        outer_next = outer_dec;
                        if (skip)
                        begin
                            if (outer_dec == 32'd0)
                            begin
                                em_valid = 1'b1; em.result_kind = KIND_END;
                                em.end_of_block = 1'b1;
                            end
                        end
                        else
                        begin
                            em_valid = 1'b1;
                            em.x_bin = {coff_c[31], coff_c} + {17'd0, dc_c};
                            em.y_bin = rowb_c;
                            em.value_bits = vf_c ? v : short_bits_x[31:0];
                            em.end_of_block = (outer_dec == 32'd0);
                        end
                    end
                    default: phase_next = ph_c;
                endcase
                if (em_valid && em.end_of_block) phase_next = PH_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE; fbc_reg <= '0; fsh_reg <= '0; coff_reg <= '0;
            roff_reg <= '0; vf_reg <= 1'b0; wx_reg <= 1'b0; wy_reg <= 1'b0;
            outer_reg <= '0; inner_reg <= '0; rowb_reg <= '0; colb_reg <= '0;
            dw_reg <= '0; dc_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_pop)
            begin
                phase_reg <= phase_next; fbc_reg <= fbc_next; fsh_reg <= fsh_next;
                coff_reg <= coff_next; roff_reg <= roff_next; vf_reg <= vf_next;
                wx_reg <= wx_next; wy_reg <= wy_next; outer_reg <= outer_next;
                inner_reg <= inner_next; rowb_reg <= rowb_next; colb_reg <= colb_next;
                dw_reg <= dw_next; dc_reg <= dc_next;
            end
            if (item_pop && em_valid) res_valid_reg <= 1'b1;
            else if (res_ready) res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop && em_valid) res_reg <= em;
    end

endmodule

// ===== hdl/contact_matrix_block_decoder.sv =====
// Contact matrix block decoder.
// in_ch carries one decompressed block byte per transfer, little-endian,
// with block_start set on the first byte of each block; that byte restarts
// the parser. out_ch carries one result per transfer: a contact record
// (kind 0), a plain block end (kind 1) or a malformed-block error (kind 2),
// with end_of_block set on the block's last result.
// cfg_ch writes the 4-bit format version; it is always ready. The user must
// write it only while no byte is in flight; the block does not enforce this.
// Bytes go through a two-entry queue into the parser, which handles one
// byte per cycle while out_ch does not stall. A transferred byte waits in
// the queue until the parser takes it; its result is registered and stays
// valid on out_ch until taken.
// When out_ch stalls, the result register holds, the parser takes no further
// byte, and the queue absorbs up to two more bytes before in_ch.ready drops.
// Reset clears the queue and the result valid flag, sets the version to 9,
// and leaves the parser waiting for a block start.
module contact_matrix_block_decoder (
    input  logic      clk,
    input  logic      rst_n,
    cmbd_in_if.sink   in_ch,
    cmbd_out_if.source out_ch,
    cmbd_cfg_if.sink  cfg_ch
);
    import cmbd_pkg::*;

    logic       item_valid;
    item_t      item;
    logic       item_pop;
    logic [3:0] version_reg;
    result_t    res;
    logic       res_valid;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) version_reg <= VERSION_RESET;
        else if (cfg_ch.valid) version_reg <= cfg_ch.data;
    end

    cmbd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    cmbd_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item           (item),
        .item_pop       (item_pop),
        .format_version (version_reg),
        .res_valid      (res_valid),
        .res            (res),
        .res_ready      (out_ch.ready)
    );

    assign out_ch.valid        = res_valid;
    assign out_ch.result_kind  = res.result_kind;
    assign out_ch.x_bin        = res.x_bin;
    assign out_ch.y_bin        = res.y_bin;
    assign out_ch.value_bits   = res.value_bits;
    assign out_ch.end_of_block = res.end_of_block;

endmodule

// ===== hdl/cmbd_checker.sv =====
module cmbd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  result_kind,
    input logic [32:0] x_bin,
    input logic [32:0] y_bin,
    input logic [31:0] value_bits,
    input logic        end_of_block,
    input logic        cfg_ready
);
    import cmbd_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value_bits) && $stable(x_bin))
        else $error("stalled result changed");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> result_kind == KIND_RECORD || result_kind == KIND_END
                      || result_kind == KIND_ERROR)
        else $error("bad result kind");

    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != KIND_RECORD |->
            end_of_block && x_bin == 33'd0 && y_bin == 33'd0 && value_bits == 32'd0)
        else $error("end or error result malformed");

    a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port not ready");

endmodule

bind contact_matrix_block_decoder cmbd_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .result_kind  (out_ch.result_kind),
    .x_bin        (out_ch.x_bin),
    .y_bin        (out_ch.y_bin),
    .value_bits   (out_ch.value_bits),
    .end_of_block (out_ch.end_of_block),
    .cfg_ready    (cfg_ch.ready)
);

// ===== test/tb_contact_matrix_block_decoder.sv =====
`timescale 1ns / 100ps

module tb_contact_matrix_block_decoder;
    import cmbd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;

    cmbd_in_if  in_ch ();
    cmbd_out_if out_ch ();
    cmbd_cfg_if cfg_ch ();

    contact_matrix_block_decoder i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    typedef struct {
        logic [7:0] data_byte;
        logic       block_start;
        logic       has_result;
        result_t    result;
    } directed_row_t;

    // Predictor state.
    logic [3:0]  version_q;
    phase_t      phase_q;
    logic [2:0]  byte_cnt_q;
    logic [31:0] shift_q;
    logic [31:0] col_off_q;
    logic [31:0] row_off_q;
    logic        is_float_q;
    logic        wide_x_q;
    logic        wide_y_q;
    logic [31:0] outer_q;
    logic [31:0] inner_q;
    logic [32:0] row_bin_q;
    logic [32:0] col_bin_q;
    logic [15:0] dense_w_q;
    logic [15:0] dense_col_q;

    result_t pending_results[$];
    int      errors;
    int      records_seen;
    int      ends_seen;
    int      faults_seen;
    int      bytes_sent;
    int      cycle_cnt;
    int      send_idle_pct;
    int      recv_stall_pct;
    bit      hold_recv;

    always #4 clk = ~clk;

    function automatic logic [32:0] sext32(input logic [31:0] v);
        return {v[31], v};
    endfunction

    function automatic logic [32:0] sext_width(input logic [31:0] v, input logic wide);
        return wide ? {v[31], v} : {{17{v[15]}}, v[15:0]};
    endfunction

    // Independent exact short-to-float: sign, exponent from the leading one.
    function automatic logic [31:0] short_bits(input logic [15:0] s);
        logic [16:0] mag;
        int          lead;
        logic [31:0] frac;
        mag = s[15] ? 17'(-$signed({s[15], s})) : {1'b0, s};
        if (mag == 0)
            return 32'd0;
        lead = 0;
        for (int i = 16; i >= 0; i--)
        begin
            if (mag[i] && lead == 0)
                lead = i;
        end
        frac = 32'(mag) << (23 - lead);
        return {s[15], 8'(127 + lead), frac[22:0]};
    endfunction

    function automatic int field_bytes(input phase_t ph);
        case (ph)
            PH_FLOAT, PH_XFLAG, PH_YFLAG, PH_TYPE: return 1;
            PH_S_ROWS, PH_S_ROWNUM: return wide_y_q ? 4 : 2;
            PH_S_COLCNT, PH_S_COLNUM: return wide_x_q ? 4 : 2;
            PH_S_VAL, PH_D_VAL: return is_float_q ? 4 : 2;
            PH_D_WIDTH: return 2;
            default: return 4;
        endcase
    endfunction

    task automatic clear_block_state();
        byte_cnt_q = '0;
        shift_q = '0;
        col_off_q = '0;
        row_off_q = '0;
        is_float_q = 1'b0;
        wide_x_q = 1'b0;
        wide_y_q = 1'b0;
        outer_q = '0;
        inner_q = '0;
        row_bin_q = '0;
        col_bin_q = '0;
        dense_w_q = '0;
        dense_col_q = '0;
    endtask

    task automatic push_result(input kind_t kind, input logic [32:0] x, input logic [32:0] y,
                               input logic [31:0] bits, input logic last);
        result_t r;
        r.result_kind = kind;
        r.x_bin = x;
        r.y_bin = y;
        r.value_bits = bits;
        r.end_of_block = last;
        pending_results.insert(pending_results.size(), r);
        if (last)
            phase_q = PH_DONE;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic start);
        logic [31:0] v;
        logic [32:0] sv;
        logic        skip;
        logic        last;
        logic [31:0] bits;
        logic [32:0] x;
        logic [32:0] y;
        logic [15:0] absw;
        if (start)
        begin
            clear_block_state();
            phase_q = PH_COUNT;
        end
        if (phase_q == PH_IDLE || phase_q >= PH_DONE)
            return;
        shift_q = shift_q | (32'(b) << (8 * byte_cnt_q[1:0]));
        byte_cnt_q = byte_cnt_q + 3'd1;
        if (int'(byte_cnt_q) < field_bytes(phase_q))
            return;
        v = shift_q;
        shift_q = '0;
        byte_cnt_q = '0;
        case (phase_q)
            PH_COUNT:
                if (version_q < VERSION_HEADER)
                begin
                    if ($signed(v) <= 0)
                        push_result(KIND_END, '0, '0, '0, 1'b1);
                    else
                    begin
                        outer_q = v;
                        phase_q = PH_L_X;
                    end
                end
                else
                    phase_q = PH_COLOFF;
            PH_L_X:
            begin
                col_bin_q = sext32(v);
                phase_q = PH_L_Y;
            end
            PH_L_Y:
            begin
                row_bin_q = sext32(v);
                phase_q = PH_L_VAL;
            end
            PH_L_VAL:
            begin
                outer_q = outer_q - 1;
                phase_q = PH_L_X;
                push_result(KIND_RECORD, col_bin_q, row_bin_q, v, outer_q == 0);
            end
            PH_COLOFF:
            begin
                col_off_q = v;
                phase_q = PH_ROWOFF;
            end
            PH_ROWOFF:
            begin
                row_off_q = v;
                phase_q = PH_FLOAT;
            end
            PH_FLOAT:
            begin
                is_float_q = (v == 1);
                phase_q = (version_q > VERSION_FLAGS) ? PH_XFLAG : PH_TYPE;
            end
            PH_XFLAG:
            begin
                wide_x_q = (v == 1);
                phase_q = PH_YFLAG;
            end
            PH_YFLAG:
            begin
                wide_y_q = (v == 1);
                phase_q = PH_TYPE;
            end
            PH_TYPE:
                if (v == 32'(TYPE_SPARSE))
                    phase_q = PH_S_ROWS;
                else if (v == 32'(TYPE_DENSE))
                    phase_q = PH_D_COUNT;
                else
                    push_result(KIND_ERROR, '0, '0, '0, 1'b1);
            PH_S_ROWS:
            begin
                sv = sext_width(v, wide_y_q);
                if ($signed(sv) <= 0)
                    push_result(KIND_END, '0, '0, '0, 1'b1);
                else
                begin
                    outer_q = sv[31:0];
                    phase_q = PH_S_ROWNUM;
                end
            end
            PH_S_ROWNUM:
            begin
                row_bin_q = sext32(row_off_q) + sext_width(v, wide_y_q);
                phase_q = PH_S_COLCNT;
            end
            PH_S_COLCNT:
            begin
                sv = sext_width(v, wide_x_q);
                if ($signed(sv) > 0)
                begin
                    inner_q = sv[31:0];
                    phase_q = PH_S_COLNUM;
                end
                else
                begin
                    outer_q = outer_q - 1;
                    if (outer_q == 0)
                        push_result(KIND_END, '0, '0, '0, 1'b1);
                    else
                        phase_q = PH_S_ROWNUM;
                end
            end
            PH_S_COLNUM:
            begin
                col_bin_q = sext32(col_off_q) + sext_width(v, wide_x_q);
                phase_q = PH_S_VAL;
            end
            PH_S_VAL:
            begin
                bits = is_float_q ? v : short_bits(v[15:0]);
                last = 1'b0;
                inner_q = inner_q - 1;
                if (inner_q == 0)
                begin
                    outer_q = outer_q - 1;
                    last = (outer_q == 0);
                    phase_q = PH_S_ROWNUM;
                end
                else
                    phase_q = PH_S_COLNUM;
                push_result(KIND_RECORD, col_bin_q, row_bin_q, bits, last);
            end
            PH_D_COUNT:
            begin
                outer_q = v;
                phase_q = PH_D_WIDTH;
            end
            PH_D_WIDTH:
                if ($signed(outer_q) <= 0)
                    push_result(KIND_END, '0, '0, '0, 1'b1);
                else if (v[15:0] == 16'd0)
                    push_result(KIND_ERROR, '0, '0, '0, 1'b1);
                else
                begin
                    dense_w_q = v[15:0];
                    dense_col_q = '0;
                    row_bin_q = sext32(row_off_q);
                    phase_q = PH_D_VAL;
                end
            PH_D_VAL:
            begin
                // The record carries the position before the counters step.
                x = sext32(col_off_q) + {17'd0, dense_col_q};
                y = row_bin_q;
                absw = dense_w_q[15] ? 16'(-dense_w_q) : dense_w_q;
                if (is_float_q)
                begin
                    skip = (v[30:23] == 8'hFF) && (v[22:0] != 0);
                    bits = v;
                end
                else
                begin
                    skip = (v[15:0] == SHORT_SKIP);
                    bits = short_bits(v[15:0]);
                end
                // Negative width is read as a 17-bit magnitude, so -32768 spans 32768.
                if (dense_w_q == 16'h8000)
                begin
                    if (dense_col_q == 16'h7FFF)
                    begin
                        dense_col_q = '0;
                        row_bin_q = row_bin_q - 1;
                    end
                    else
                        dense_col_q = dense_col_q + 1;
                end
                else if (17'(dense_col_q) + 1 >= 17'(absw))
                begin
                    dense_col_q = '0;
                    row_bin_q = dense_w_q[15] ? row_bin_q - 1 : row_bin_q + 1;
                end
                else
                    dense_col_q = dense_col_q + 1;
                outer_q = outer_q - 1;
                last = (outer_q == 0);
                if (skip)
                begin
                    if (last)
                        push_result(KIND_END, '0, '0, '0, 1'b1);
                end
                else
                    push_result(KIND_RECORD, x, y, bits, last);
            end
            default: ;
        endcase
    endtask

    // Enters and returns at a falling edge; valid stays high after the transfer
    // until the next byte replaces it or the sender idles.
    task automatic send_byte(input logic [7:0] b, input logic start);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.block_start <= start;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        decode_byte(b, start);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_word(input logic [31:0] w, input int n, input logic start);
        for (int i = 0; i < n; i++)
            send_byte(w[8*i +: 8], start && i == 0);
    endtask

    task automatic write_version(input logic [3:0] ver);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= ver;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        version_q = ver;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_value(input logic is_float);
        case ($urandom_range(5))
            0: return is_float ? 32'h7FC0_0001 : 32'h0000_8000;
            1: return is_float ? 32'hFF80_0000 : 32'h0000_7FFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rand_count(input int lo, input int hi);
        case ($urandom_range(9))
            0: return 32'(-$urandom_range(3));
            1: return 32'hFFFF_8000;
            default: return 32'($urandom_range(hi, lo));
        endcase
    endfunction

    task automatic random_block();
        logic        fl;
        logic        wx;
        logic        wy;
        logic [31:0] rows;
        logic [31:0] cols;
        logic [31:0] cells;
        logic [15:0] w;
        int          n;
        int          nx;
        int          ny;
        if (version_q < VERSION_HEADER)
        begin
            cells = rand_count(1, 5);
            send_word(cells, 4, 1'b1);
            n = ($signed(cells) > 0) ? int'(cells) : 0;
            for (int i = 0; i < n * 12; i++)
                send_byte(8'($urandom_range(255)), 1'b0);
            return;
        end
        send_word($urandom(), 4, 1'b1);
        send_word($urandom(), 4, 1'b0);
        send_word($urandom(), 4, 1'b0);
        fl = 1'($urandom_range(1));
        send_byte(($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'(fl), 1'b0);
        fl = is_float_q;
        wx = 1'b0;
        wy = 1'b0;
        if (version_q > VERSION_FLAGS)
        begin
            send_byte(8'($urandom_range(1)), 1'b0);
            send_byte(($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                              : 8'($urandom_range(1)), 1'b0);
            wx = wide_x_q;
            wy = wide_y_q;
        end
        nx = wx ? 4 : 2;
        ny = wy ? 4 : 2;
        case ($urandom_range(9))
            0: send_byte(8'($urandom_range(255)), 1'b0);
            1, 2, 3, 4:
            begin
                send_byte(TYPE_SPARSE, 1'b0);
                rows = rand_count(1, 3);
                send_word(rows, ny, 1'b0);
                while (phase_q == PH_S_ROWNUM)
                begin
                    send_word($urandom(), ny, 1'b0);
                    cols = rand_count(1, 3);
                    send_word(cols, nx, 1'b0);
                    while (phase_q == PH_S_COLNUM)
                    begin
                        send_word($urandom(), nx, 1'b0);
                        send_word(rand_value(fl), fl ? 4 : 2, 1'b0);
                    end
                end
            end
            default:
            begin
                send_byte(TYPE_DENSE, 1'b0);
                cells = rand_count(1, 8);
                send_word(cells, 4, 1'b0);
                case ($urandom_range(7))
                    0: w = 16'd0;
                    1: w = 16'(-$urandom_range(4, 1));
                    2: w = 16'h8000;
                    default: w = 16'($urandom_range(4, 1));
                endcase
                send_word({16'($urandom()), w}, 2, 1'b0);
                while (phase_q == PH_D_VAL)
                    send_word(rand_value(fl), fl ? 4 : 2, 1'b0);
            end
        endcase
        // Occasional trailing noise past the end of the block.
        if ($urandom_range(3) == 0)
            send_byte(8'($urandom_range(255)), 1'b0);
    endtask

    // Receiver.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= !hold_recv &&
                            !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result kind=%0d", out_ch.result_kind);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.result_kind !== want.result_kind)
                begin
                    $error("result_kind expected %0d got %0d", want.result_kind,
                           out_ch.result_kind);
                    errors++;
                end
                if (out_ch.x_bin !== want.x_bin)
                begin
                    $error("x_bin expected %h got %h", want.x_bin, out_ch.x_bin);
                    errors++;
                end
                if (out_ch.y_bin !== want.y_bin)
                begin
                    $error("y_bin expected %h got %h", want.y_bin, out_ch.y_bin);
                    errors++;
                end
                if (out_ch.value_bits !== want.value_bits)
                begin
                    $error("value_bits expected %h got %h", want.value_bits,
                           out_ch.value_bits);
                    errors++;
                end
                if (out_ch.end_of_block !== want.end_of_block)
                begin
                    $error("end_of_block expected %0d got %0d", want.end_of_block,
                           out_ch.end_of_block);
                    errors++;
                end
                case (want.result_kind)
                    KIND_RECORD: records_seen++;
                    KIND_END: ends_seen++;
                    default: faults_seen++;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Long receiver hold-off, counted in its own process.
    task automatic long_hold();
        hold_recv = 1'b1;
        repeat (60) @(posedge clk);
        hold_recv = 1'b0;
    endtask

    initial
    begin
        directed_row_t rows_tbl[$];
        directed_row_t row;
        logic [3:0]    versions[6];
        clk = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.block_start = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        hold_recv = 1'b0;
        errors = 0;
        records_seen = 0;
        ends_seen = 0;
        faults_seen = 0;
        bytes_sent = 0;
        cycle_cnt = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        version_q = VERSION_RESET;
        phase_q = PH_IDLE;
        clear_block_state();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: ignored bytes before a block, then a version 9 block with a
        // bad matrix type, which must come back as an error at once.
        rows_tbl = '{
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h01, 1'b1, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0}, '{8'h80, 1'b0, 1'b0, '0},
            '{8'h01, 1'b0, 1'b0, '0}, '{8'h01, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h07, 1'b0, 1'b1, '{KIND_ERROR, 33'd0, 33'd0, 32'd0, 1'b1}},
            '{8'h55, 1'b0, 1'b0, '0}
        };
        foreach (rows_tbl[i])
        begin
            row = rows_tbl[i];
            send_byte(row.data_byte, row.block_start);
            if (row.has_result && (pending_results.size() == 0
                || pending_results[$] !== row.result))
            begin
                $error("directed row %0d: table and predictor disagree", i);
                errors++;
            end
        end

        versions = '{4'd1, 4'd6, 4'd7, 4'd8, 4'd15, 4'd9};
        for (int phase_i = 0; phase_i < 6; phase_i++)
        begin
            write_version(versions[phase_i]);
            case (phase_i % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            if (phase_i == 2)
                fork
                    long_hold();
                join_none
            while (bytes_sent < 150 * (phase_i + 1) + 20)
                random_block();
        end

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Sent %0d bytes over six format versions and four pacing phases.",
                 bytes_sent);
        $display("Checked %0d records, %0d plain block ends, %0d malformed blocks.",
                 records_seen, ends_seen, faults_seen);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
